/* rtl/oets_pkg.sv */
// ----------------------------------------------------------------------------
// oets_pkg
// Shared types and constants for the odd-even transposition sorter.
// ----------------------------------------------------------------------------
package oets_pkg;

    localparam int VALUE_W = 32;

    // Operation applied to every cell of the row together.
    typedef enum logic [2:0] {
        CELL_HOLD = 3'd0,
        CELL_LOAD = 3'd1,
        CELL_EMIT = 3'd2,
        CELL_ODD  = 3'd3,
        CELL_EVEN = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

endpackage

/* rtl/odd_even_transposition_sorter.sv */
// ----------------------------------------------------------------------------
// odd_even_transposition_sorter
// Collects a set of signed values, sorts it ascending in a row of
// compare-exchange cells and emits the sorted set as a burst.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-----------------------------------------
//  input    | i_valid / o_ready    | i_value, i_last
//  output   | o_valid / i_ready    | o_value_res, o_last_res, o_overflow
//
//  Loading shifts each accepted input element into the cell row,
//  but elements beyond MAX_ELEMENTS are dropped.
//  Sorting runs in rounds (odd pairs, then even pairs) and ends
//  after the first round without a swap: at most ceil(n/2) + 1 rounds.
//  Emitting shifts the row toward cell 0 once per output transaction.
//  A stalled output holds the row; no input is taken while sorting or
//  emitting. Reset clears the valid bits, the count and the state.
// ----------------------------------------------------------------------------
module odd_even_transposition_sorter #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [oets_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [oets_pkg::VALUE_W-1:0] o_value_res,
    output logic                                o_last_res,
    output logic                                o_overflow
);
    import oets_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    typedef enum logic [3:0] {
        ST_LOAD = 4'b0001,
        ST_ODD  = 4'b0010,
        ST_EVEN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_dropped;
    logic               n_dropped;
    logic               r_swapped;
    logic               n_swapped;
    t_cell_ctrl         w_ctrl;
    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_full;
    logic               w_swap_now;

    logic signed [VALUE_W-1:0] w_value [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]   w_valid;
    logic [MAX_ELEMENTS-1:0]   w_gt;
    logic [MAX_ELEMENTS-1:0]   w_swap;

    assign o_ready    = (r_state == ST_LOAD);
    assign o_valid    = (r_state == ST_EMIT);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_acc  = o_valid && i_ready;
    assign w_full     = (r_count == CNT_W'(MAX_ELEMENTS));
    assign w_swap_now = |w_swap;

    always_comb begin
        w_ctrl.op = CELL_HOLD;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc && !w_full) begin
                    w_ctrl.op = CELL_LOAD;
                end
            end
            ST_ODD:  w_ctrl.op = CELL_ODD;
            ST_EVEN: w_ctrl.op = CELL_EVEN;
            ST_EMIT: begin
                if (w_out_acc) begin
                    w_ctrl.op = CELL_EMIT;
                end
            end
            default: w_ctrl.op = CELL_HOLD;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_swapped = r_swapped;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_state   = ST_ODD;
                        n_swapped = 1'b0;
                    end
                end
            end
            ST_ODD: begin
                n_swapped = w_swap_now;
                n_state   = ST_EVEN;
            end
            ST_EVEN: begin
                // A round with no swap in either phase leaves the set sorted.
                n_swapped = 1'b0;
                if (r_swapped || w_swap_now) begin
                    n_state = ST_ODD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_acc && o_last_res) begin
                    n_state   = ST_LOAD;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_swapped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_swapped <= n_swapped;
        end
    end

    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left_value;
        logic                      w_left_valid;
        logic                      w_left_gt;
        logic signed [VALUE_W-1:0] w_right_value;
        logic                      w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_value = i_value;
            assign w_left_valid = 1'b1;
            assign w_left_gt    = 1'b0;
        end else begin : g_body
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_tail
            assign w_right_value = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        oets_cell #(
            .ODD_POS (1'(g % 2))
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_value  (w_left_value),
            .i_left_valid  (w_left_valid),
            .i_left_gt     (w_left_gt),
            .i_right_value (w_right_value),
            .i_right_valid (w_right_valid),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_gt          (w_gt[g]),
            .o_swap        (w_swap[g])
        );
    end

    assign o_value_res = w_value[0];
    assign o_last_res  = !w_valid[1];
    assign o_overflow  = r_dropped;

    a_emit_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_valid[0])
        else $error("emitting from an empty cell row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_last) |=> (r_state == ST_ODD))
        else $error("final input transaction did not start the sort");

    a_burst_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_res) |=> (r_count == '0) && !r_dropped && (w_valid == '0))
        else $error("set state not cleared after the final result");

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> ($countones(w_valid) == int'(r_count)))
        else $error("cell valid bits disagree with the element count");

endmodule

/* rtl/oets_cell.sv */
// ----------------------------------------------------------------------------
// oets_cell
// One cell of the sorting row: holds one element and its valid bit, shifts
// with its neighbors while loading and emitting, and takes part in one
// compare-exchange pair during each sort phase.
// ----------------------------------------------------------------------------
module oets_cell #(
    parameter bit ODD_POS = 1'b0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  oets_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [oets_pkg::VALUE_W-1:0] i_left_value,
    input  logic                                i_left_valid,
    input  logic                                i_left_gt,
    input  logic signed [oets_pkg::VALUE_W-1:0] i_right_value,
    input  logic                                i_right_valid,
    output logic signed [oets_pkg::VALUE_W-1:0] o_value,
    output logic                                o_valid,
    output logic                                o_gt,
    output logic                                o_swap
);
    import oets_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      r_valid;
    logic                      n_valid;
    logic                      w_low;
    logic                      w_high;

    // This cell is the lower member of its pair when the phase parity matches
    // its own position parity, and the upper member otherwise.
    assign w_low  = ((i_ctrl.op == CELL_ODD) && ODD_POS) ||
                    ((i_ctrl.op == CELL_EVEN) && !ODD_POS);
    assign w_high = ((i_ctrl.op == CELL_ODD) && !ODD_POS) ||
                    ((i_ctrl.op == CELL_EVEN) && ODD_POS);

    assign o_gt   = r_valid && i_right_valid && (r_value > i_right_value);
    assign o_swap = w_low && o_gt;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        case (i_ctrl.op) inside
            CELL_LOAD: begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
            CELL_EMIT: begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
            CELL_ODD, CELL_EVEN: begin
                if (w_low && o_gt) begin
                    n_value = i_right_value;
                end else if (w_high && i_left_gt) begin
                    n_value = i_left_value;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

/* dv/sorted_burst_checker.sv */
// ----------------------------------------------------------------------------
// sorted_burst_checker
// Watches both channels of the sorter, keeps its own copy of the open set,
// sorts it when the closing transaction arrives and compares every result
// transaction, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
module sorted_burst_checker #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [oets_pkg::VALUE_W-1:0] i_value,
    input  logic                                i_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [oets_pkg::VALUE_W-1:0] i_value_res,
    input  logic                                i_last_res,
    input  logic                                i_overflow,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import oets_pkg::*;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      overflow;
    } t_sorted_word;

    logic signed [VALUE_W-1:0] set_values [MAX_ELEMENTS];
    int                        set_fill = 0;
    logic                      set_dropped = 1'b0;
    t_sorted_word              sorted_words [$];
    int                        mismatches = 0;
    int                        pending_count = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_count;

    function automatic logic exchange_pair(input int k);
        logic signed [VALUE_W-1:0] held;
        if (set_values[k] > set_values[k+1]) begin
            held            = set_values[k];
            set_values[k]   = set_values[k+1];
            set_values[k+1] = held;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic collect_and_sort(input logic signed [VALUE_W-1:0] value,
                                    input logic last);
        t_sorted_word word;
        logic         swapped;
        int           k;
        if (set_fill < MAX_ELEMENTS) begin
            set_values[set_fill] = value;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            // Each round handles the odd pairs first, then the even pairs.
            swapped = 1'b1;
            while (swapped) begin
                swapped = 1'b0;
                for (k = 1; k + 1 < set_fill; k += 2) begin
                    if (exchange_pair(k)) swapped = 1'b1;
                end
                for (k = 0; k + 1 < set_fill; k += 2) begin
                    if (exchange_pair(k)) swapped = 1'b1;
                end
            end
            for (k = 0; k < set_fill; k++) begin
                word.value    = set_values[k];
                word.last     = (k + 1 == set_fill);
                word.overflow = set_dropped;
                sorted_words.push_back(word);
            end
            set_fill    = 0;
            set_dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (!i_rst_n) begin
            set_fill    = 0;
            set_dropped = 1'b0;
            sorted_words.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                collect_and_sort(i_value, i_last);
            end
            if (i_out_valid && i_out_ready) begin
                if (sorted_words.size() == 0) begin
                    $display("%0t: unexpected result: value %0d last %0b overflow %0b",
                             $time, i_value_res, i_last_res, i_overflow);
                    mismatches++;
                end else begin
                    want = sorted_words.pop_front();
                    if (want.value !== i_value_res || want.last !== i_last_res ||
                        want.overflow !== i_overflow) begin
                        $display("%0t: result mismatch: expected value %0d last %0b",
                                 $time, want.value, want.last,
                                 " overflow %0b, got value %0d last %0b overflow %0b",
                                 want.overflow, i_value_res, i_last_res, i_overflow);
                        mismatches++;
                    end
                end
            end
        end
        pending_count <= sorted_words.size();
    end

endmodule

/* dv/tb_odd_even_transposition_sorter.sv */
// ----------------------------------------------------------------------------
// tb_odd_even_transposition_sorter
// Drives sets of signed values into the sorter, directed corner sets first
// and then random sets under three idling patterns, and reports the verdict
// of the checker once every sorted burst has drained.
// ----------------------------------------------------------------------------
module tb_odd_even_transposition_sorter;
    timeunit 1ns;
    timeprecision 1ps;

    import oets_pkg::*;

    localparam int MAX_ELEMENTS = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 100;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic signed [VALUE_W-1:0] i_value;
    logic                      i_last;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [VALUE_W-1:0] o_value_res;
    logic                      o_last_res;
    logic                      o_overflow;

    int tx_idle_pct = 15;
    int rx_idle_pct = 81;
    int cycle_count = 0;
    int random_items = 0;
    int fail_count;
    int pending_results;

    odd_even_transposition_sorter #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_value    (i_value),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value_res(o_value_res),
        .o_last_res (o_last_res),
        .o_overflow (o_overflow)
    );

    sorted_burst_checker #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_value     (i_value),
        .i_last      (i_last),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_value_res (o_value_res),
        .i_last_res  (o_last_res),
        .i_overflow  (o_overflow),
        .o_fail_count(fail_count),
        .o_pending   (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Extremes and a narrow band around zero make duplicates and ties common.
    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2, 3:    return int'($urandom_range(6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_value(input logic signed [VALUE_W-1:0] value, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        i_last  <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_random_set(input int set_size);
        int i;
        for (i = 0; i < set_size; i++) begin
            send_value(random_value(), i == set_size - 1);
        end
        random_items += set_size;
    endtask

    // The opening set of each phase is a full or overflowing one; the rest
    // are mostly short so that many bursts end in each phase.
    task automatic run_random_phase(input int tx_pct, input int rx_pct, input int first_size);
        int goal;
        goal        = random_items + ITEMS_PER_PHASE;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        send_random_set(first_size);
        while (random_items < goal) begin
            if ($urandom_range(15) == 0) begin
                send_random_set($urandom_range(40, 20));
            end else begin
                send_random_set($urandom_range(8, 1));
            end
        end
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        i_last  = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A set of one element.
        send_value(VALUE_MAX, 1'b1);
        // Both extremes, zero and its neighbors, out of order.
        send_value(VALUE_MAX, 1'b0);
        send_value(VALUE_MIN, 1'b0);
        send_value(1, 1'b0);
        send_value(-1, 1'b0);
        send_value(0, 1'b1);
        // Already ascending.
        send_value(VALUE_MIN, 1'b0);
        send_value(-1, 1'b0);
        send_value(0, 1'b0);
        send_value(1, 1'b0);
        send_value(VALUE_MAX, 1'b1);
        // Equal pair: no swap may happen.
        send_value(5, 1'b0);
        send_value(5, 1'b1);
        // Strictly descending set needs the most rounds for its size.
        for (i = 8; i >= 1; i--) begin
            send_value(i, i == 1);
        end

        run_random_phase(15, 81, MAX_ELEMENTS + 1 + $urandom_range(2));
        run_random_phase(81, 15, MAX_ELEMENTS);
        run_random_phase(0, 0, MAX_ELEMENTS + 1 + $urandom_range(2));
        i_valid <= 1'b0;

        // The clock edge below lets the checker account for the final transaction.
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/oets_pkg.sv
rtl/oets_cell.sv
rtl/odd_even_transposition_sorter.sv
dv/sorted_burst_checker.sv
dv/tb_odd_even_transposition_sorter.sv
